// File: rtl/core/digit_dominated_prefix_count_assert.svh
// Assertion macros for the digit-dominated prefix count block.
// Expect i_clk and i_rst_n in the scope of each use.
`ifndef DIGIT_DOMINATED_PREFIX_COUNT_ASSERT_SVH
`define DIGIT_DOMINATED_PREFIX_COUNT_ASSERT_SVH

// Same-cycle implication.
`define DDPC_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("ddpc check failed");

// Next-cycle implication.
`define DDPC_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("ddpc check failed");

`endif

// File: rtl/core/ddpc_pkg.sv
// Shared types and constants for the digit-dominated prefix count block.
// No dependencies.
`timescale 1ns / 1ps

package ddpc_pkg;
    localparam int VALUE_WIDTH = 64;
    localparam int RADIX_WIDTH = 8;
    localparam int PROD_WIDTH  = VALUE_WIDTH + RADIX_WIDTH + 1;
    localparam int BYTE_STEPS  = VALUE_WIDTH / 8;
    localparam int STEP_WIDTH  = $clog2(BYTE_STEPS);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIVM,
        ST_DIVY,
        ST_MULY,
        ST_MULM,
        ST_DONE
    } t_state;
endpackage

// File: rtl/core/digit_dominated_prefix_count.sv
// Top level of the digit-dominated prefix count block.
// Depends on ddpc_pkg and digit_dominated_prefix_count_assert.svh.
`timescale 1ns / 1ps
`include "digit_dominated_prefix_count_assert.svh"

// Counts k in 0..upper_bound whose every base-radix digit is at most the
// matching digit of limit_value, saturating at 2^64-1.
// Input channel: i_in_valid with o_in_stall; a beat is taken when valid is
// high and stall is low. Output channel: o_out_valid with i_out_stall.
// The user must write the radix register (i_cfg_we / i_cfg_wdata) only
// while idle; the block does not enforce it. A radix of 0 or 1 acts as 2.
// Digits are taken least significant first. Each digit costs byte-wise
// division for each operand through one shared 16/8 divide step (ST_DIVM,
// then ST_DIVY), then ST_MULY and ST_MULM on one shared 64x9 multiplier.
// The work ends once both quotients reach zero, after D digits, D the digit
// count of the larger operand (at most 64 digits); at least one digit is
// always processed.
// One item is in flight; o_in_stall is high from acceptance until the
// result beat is taken. The result is held while i_out_stall is high.
// Reset (synchronous, active low) sets the radix to 2 and drops any item.
module digit_dominated_prefix_count (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [ddpc_pkg::RADIX_WIDTH-1:0] i_cfg_wdata,
    input  logic                            i_in_valid,
    output logic                            o_in_stall,
    input  logic [ddpc_pkg::VALUE_WIDTH-1:0] i_limit_value,
    input  logic [ddpc_pkg::VALUE_WIDTH-1:0] i_upper_bound,
    output logic                            o_out_valid,
    input  logic                            i_out_stall,
    output logic [ddpc_pkg::VALUE_WIDTH-1:0] o_dominated_count
);
    import ddpc_pkg::*;

    t_state                  r_state, n_state;
    logic [RADIX_WIDTH-1:0]  r_radix;
    logic [VALUE_WIDTH-1:0]  r_m, r_y, r_lower, r_cnt, r_prod;
    logic [RADIX_WIDTH-1:0]  r_rem, r_md, r_yd;
    logic [STEP_WIDTH-1:0]   r_step;

    // shared divide step
    logic [VALUE_WIDTH-1:0]  div_op;
    logic [RADIX_WIDTH-1:0]  div_byte, div_q, div_rem;
    logic [RADIX_WIDTH:0]    part;
    logic [VALUE_WIDTH-1:0]  div_shift;

    // shared multiplier
    logic [RADIX_WIDTH:0]    mul_b;
    logic [PROD_WIDTH-1:0]   mul_p;
    logic [VALUE_WIDTH-1:0]  mul_sat;
    logic [VALUE_WIDTH:0]    add_sum;
    logic [VALUE_WIDTH-1:0]  add_sat;
    logic                    over;

    always_comb begin
        div_op   = (r_state == ST_DIVY) ? r_y : r_m;
        div_byte = div_op[VALUE_WIDTH-1 -: RADIX_WIDTH];
        part     = '0;
        div_q    = '0;
        div_rem  = (r_step == '0) ? '0 : r_rem;
        for (int j = RADIX_WIDTH - 1; j >= 0; j--) begin
            part = {div_rem, div_byte[j]};
            if (part >= {1'b0, r_radix}) begin
                part     = part - {1'b0, r_radix};
                div_q[j] = 1'b1;
            end
            div_rem = part[RADIX_WIDTH-1:0];
        end
        div_shift = {div_op[VALUE_WIDTH-RADIX_WIDTH-1:0], div_q};
    end

    assign over    = r_yd > r_md;
    assign mul_b   = (r_state == ST_MULY) ? {1'b0, r_yd} : ({1'b0, r_md} + 1'b1);
    assign mul_p   = {{(PROD_WIDTH-VALUE_WIDTH){1'b0}}, r_lower} * PROD_WIDTH'(mul_b);
    assign mul_sat = (|mul_p[PROD_WIDTH-1:VALUE_WIDTH]) ? '1 : mul_p[VALUE_WIDTH-1:0];
    assign add_sum = {1'b0, r_prod} + {1'b0, r_cnt};
    assign add_sat = add_sum[VALUE_WIDTH] ? '1 : add_sum[VALUE_WIDTH-1:0];

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: if (i_in_valid) n_state = ST_DIVM;
            ST_DIVM: if (r_step == STEP_WIDTH'(BYTE_STEPS - 1)) n_state = ST_DIVY;
            ST_DIVY: if (r_step == STEP_WIDTH'(BYTE_STEPS - 1)) n_state = ST_MULY;
            ST_MULY: n_state = ST_MULM;
            ST_MULM: n_state = (r_m == '0 && r_y == '0) ? ST_DONE : ST_DIVM;
            ST_DONE: if (!i_out_stall) n_state = ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_radix <= RADIX_WIDTH'(2);
            r_step  <= '0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                r_radix <= (i_cfg_wdata < RADIX_WIDTH'(2)) ? RADIX_WIDTH'(2) : i_cfg_wdata;
            end
            if (r_state == ST_DIVM || r_state == ST_DIVY) begin
                r_step <= r_step + 1'b1;
            end else begin
                r_step <= '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (r_state)
            ST_IDLE: begin
                r_m     <= i_limit_value;
                r_y     <= i_upper_bound;
                r_lower <= VALUE_WIDTH'(1);
                r_cnt   <= VALUE_WIDTH'(1);
            end
            ST_DIVM: begin
                r_m   <= div_shift;
                r_rem <= div_rem;
                r_md  <= div_rem;
            end
            ST_DIVY: begin
                r_y   <= div_shift;
                r_rem <= div_rem;
                r_yd  <= div_rem;
            end
            ST_MULY: r_prod <= mul_sat;
            ST_MULM: begin
                // a digit above the limit makes every lower choice count
                r_lower <= mul_sat;
                r_cnt   <= over ? mul_sat : add_sat;
            end
            ST_DONE: ;
            default: ;
        endcase
    end

    assign o_in_stall        = (r_state != ST_IDLE);
    assign o_out_valid       = (r_state == ST_DONE);
    assign o_dominated_count = r_cnt;

    `DDPC_ASSERT_NOW(a_radix_min, 1'b1, r_radix >= RADIX_WIDTH'(2))
    `DDPC_ASSERT_NOW(a_out_busy, o_out_valid, o_in_stall)
    `DDPC_ASSERT_NOW(a_rem_range, (r_state == ST_MULY), (r_md < r_radix) && (r_yd < r_radix))
    `DDPC_ASSERT_NEXT(a_over_cnt, (r_state == ST_MULM) && over, r_cnt == r_lower)
endmodule
